// ===== hdl/repeating_timer_table_macros.svh =====
// Assertion macros for the repeating timer table checker.
// No dependencies; included by the checker file only.
`ifndef REPEATING_TIMER_TABLE_MACROS_SVH
`define REPEATING_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define RTT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// next-cycle implication
`define RTT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

// ===== hdl/rtt_pkg.sv =====
// Shared types and constants of the repeating timer table.
// No dependencies; used by every module of the block.
`default_nettype none
package rtt_pkg;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_SLOTS       = 64;
  localparam int SLOT_W          = $clog2(MAX_SLOTS);
  localparam int MAX_RESULTS     = 16;
  localparam int TIME_W          = 48;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam logic [TIME_W-1:0] MASK48 = {TIME_W{1'b1}};
  localparam logic [31:0]       MASK32 = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_ADD_ONE  = 2'd0;
  localparam logic [1:0] CMD_ADD_PER  = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // search wavefront handed from cell to cell
  typedef struct packed {
    logic              wave;
    logic              found;
    logic [TIME_W-1:0] deadline;
    logic [15:0]       id;
    logic [7:0]        dest;
    logic              periodic;
    logic [31:0]       interval;
    logic [SLOT_W-1:0] slot;
  } link_t;

  // controls broadcast from the sequencer to all cells
  typedef struct packed {
    logic              add_mode;
    logic [TIME_W-1:0] now;
    logic [15:0]       add_id;
    logic [7:0]        add_dest;
    logic [TIME_W-1:0] add_deadline;
    logic              add_periodic;
    logic [31:0]       add_interval;
    logic              cancel;
    logic [15:0]       cancel_id;
    logic              clr_fired;
    logic              upd;
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_kill;
    logic [TIME_W-1:0] upd_deadline;
  } bcast_t;
endpackage
`default_nettype wire

// ===== hdl/rtt_cell.sv =====
// One timer slot of the chain, with its stage of the search wavefront.
// Depends on rtt_pkg.
`default_nettype none
module rtt_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rtt_pkg::bcast_t bc,
  input  wire rtt_pkg::link_t  link_in,
  output rtt_pkg::link_t       link_out
);
  localparam logic [rtt_pkg::SLOT_W-1:0] MY_SLOT = rtt_pkg::SLOT_W'(IDX);

  logic                       valid;
  logic                       fired;
  logic [15:0]                id;
  logic [7:0]                 dest;
  logic [rtt_pkg::TIME_W-1:0] deadline;
  logic                       periodic;
  logic [31:0]                interval;
  rtt_pkg::link_t             link_next;
  logic                       claim;
  logic                       better;

  always_comb begin
    link_next = link_in;
    claim  = link_in.wave && bc.add_mode && !link_in.found && !valid;
    better = link_in.wave && !bc.add_mode && valid && !fired && (deadline <= bc.now) &&
             (!link_in.found || (deadline < link_in.deadline) ||
              ((deadline == link_in.deadline) && (id < link_in.id)));
    if (claim) begin
      link_next.found = 1'b1;
      link_next.slot  = MY_SLOT;
    end else if (better) begin
      link_next.found    = 1'b1;
      link_next.deadline = deadline;
      link_next.id       = id;
      link_next.dest     = dest;
      link_next.periodic = periodic;
      link_next.interval = interval;
      link_next.slot     = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.wave <= 1'b0;
    end else begin
      link_out <= link_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      fired <= 1'b0;
    end else begin
      if (bc.clr_fired) begin
        fired <= 1'b0;
      end
      if (claim) begin
        valid    <= 1'b1;
        id       <= bc.add_id;
        dest     <= bc.add_dest;
        deadline <= bc.add_deadline;
        periodic <= bc.add_periodic;
        interval <= bc.add_interval;
      end
      if (bc.cancel && valid && (id == bc.cancel_id)) begin
        valid <= 1'b0;
      end
      if (bc.upd && (bc.upd_slot == MY_SLOT)) begin
        fired <= 1'b1;
        if (bc.upd_kill) begin
          valid <= 1'b0;
        end else begin
          deadline <= bc.upd_deadline;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rtt_div.sv =====
// Restoring divider, one quotient bit per cycle, for missed-period counts.
// Depends on rtt_pkg.
`default_nettype none
module rtt_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rtt_pkg::TIME_W-1:0] dividend,
  input  wire logic [31:0]                divisor,
  output logic                            done,
  output logic [rtt_pkg::TIME_W-1:0]      quotient
);
  localparam int STEP_W = $clog2(rtt_pkg::TIME_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [32:0]       trial;
  logic              ge;

  assign trial = {rem, quotient[rtt_pkg::TIME_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        quotient <= {quotient[rtt_pkg::TIME_W-2:0], ge};
        step     <= step + 1'b1;
        if (step == STEP_W'(rtt_pkg::TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/repeating_timer_table.sv =====
// Table of one-shot and periodic timers held in a chain of slot cells.
// Depends on rtt_pkg, rtt_cell and rtt_div.
//
// An add or a tick sends a search wavefront down the chain of TIMER_SLOTS cells, one cell
// a cycle. A tick runs one search per expired timer, plus, unless the result cap is
// reached, one final search that finds nothing; a periodic timer's missed-period count
// comes from a divider giving one quotient bit per cycle. A tick delivers at most 16
// timeouts; the rest fire on a later tick. The input is taken only while no request is
// in progress.
`default_nettype none
module repeating_timer_table #(
  parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  dest_id,
  input  wire logic [31:0] delay,
  input  wire logic [15:0] cancel_id,
  input  wire logic [47:0] now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      timer_id,
  output logic [7:0]       notify_dest,
  output logic [31:0]      timeout_count,
  output logic             last
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD     = 4'd1;
  localparam logic [3:0] S_ADD_OUT = 4'd2;
  localparam logic [3:0] S_CANCEL  = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_PUSH    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_SAT     = 4'd8;
  localparam logic [3:0] S_FLUSH   = 4'd9;

  logic [3:0]                 state;
  rtt_pkg::bcast_t            bc;
  rtt_pkg::link_t             links [TIMER_SLOTS+1];
  rtt_pkg::link_t             best;
  logic                       start;
  logic                       launch;
  logic [15:0]                next_id;
  logic                       add_found;
  logic [rtt_pkg::CNT_W-1:0]  n;
  logic                       pend_v;
  logic [15:0]                pend_id;
  logic [7:0]                 pend_dest;
  logic [31:0]                pend_cnt;
  logic [31:0]                cnt;
  logic [63:0]                prod;
  logic                       div_start;
  logic [rtt_pkg::TIME_W-1:0] div_a;
  logic [31:0]                div_b;
  logic                       div_done;
  logic [rtt_pkg::TIME_W-1:0] div_q;
  logic                       out_free;
  logic [48:0]                add_sum;
  logic [64:0]                adv_sum;
  logic [rtt_pkg::TIME_W-1:0] adv_dl;
  logic [31:0]                add_iv;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign add_iv  = ((cmd == rtt_pkg::CMD_ADD_PER) && (delay == 32'd0)) ? 32'd1 : delay;
  assign add_sum = {1'b0, now_time} + {17'b0, add_iv};
  assign adv_sum = {17'b0, best.deadline} + {1'b0, prod};
  assign adv_dl  = (adv_sum > {17'b0, rtt_pkg::MASK48}) ? rtt_pkg::MASK48
                                                        : adv_sum[rtt_pkg::TIME_W-1:0];

  // launch follows start in the next cycle so the cells have taken any slot update first
  always_comb begin
    links[0]       = '0;
    links[0].wave  = launch;
  end

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    rtt_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bc       (bc),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  rtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start        <= 1'b0;
      launch       <= 1'b0;
      div_start    <= 1'b0;
      next_id      <= '0;
      pend_v       <= 1'b0;
      n            <= '0;
      out_valid    <= 1'b0;
      bc.cancel    <= 1'b0;
      bc.clr_fired <= 1'b0;
      bc.upd       <= 1'b0;
    end else begin
      start        <= 1'b0;
      launch       <= start;
      div_start    <= 1'b0;
      bc.cancel    <= 1'b0;
      bc.clr_fired <= 1'b0;
      bc.upd       <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bc.now          <= now_time;
            bc.add_id       <= next_id;
            bc.add_dest     <= dest_id;
            bc.add_deadline <= add_sum[48] ? rtt_pkg::MASK48 : add_sum[47:0];
            bc.add_periodic <= (cmd == rtt_pkg::CMD_ADD_PER);
            bc.add_interval <= add_iv;
            bc.cancel_id    <= cancel_id;
            unique case (cmd)
              rtt_pkg::CMD_ADD_ONE, rtt_pkg::CMD_ADD_PER: begin
                bc.add_mode <= 1'b1;
                start       <= 1'b1;
                state       <= S_ADD;
              end
              rtt_pkg::CMD_CANCEL: begin
                bc.cancel <= 1'b1;
                state     <= S_CANCEL;
              end
              default: begin
                bc.add_mode  <= 1'b0;
                bc.clr_fired <= 1'b1;
                start        <= 1'b1;
                n            <= '0;
                pend_v       <= 1'b0;
                state        <= S_SCAN;
              end
            endcase
          end
        end
        S_ADD: begin
          if (links[TIMER_SLOTS].wave) begin
            add_found <= links[TIMER_SLOTS].found;
            state     <= S_ADD_OUT;
          end
        end
        S_ADD_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= add_found ? rtt_pkg::KIND_ADDED : rtt_pkg::KIND_FULL;
            timer_id      <= add_found ? next_id : 16'd0;
            notify_dest   <= 8'd0;
            timeout_count <= 32'd0;
            last          <= 1'b1;
            if (add_found) begin
              next_id <= next_id + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        S_CANCEL: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (links[TIMER_SLOTS].wave) begin
            best  <= links[TIMER_SLOTS];
            div_a <= bc.now - links[TIMER_SLOTS].deadline;
            div_b <= (links[TIMER_SLOTS].interval == 32'd0) ? 32'd1
                                                            : links[TIMER_SLOTS].interval;
            priority if (links[TIMER_SLOTS].found && pend_v) begin
              state <= S_PUSH;
            end else if (links[TIMER_SLOTS].found) begin
              div_start <= links[TIMER_SLOTS].periodic;
              cnt       <= 32'd1;
              state     <= links[TIMER_SLOTS].periodic ? S_DIV : S_SAT;
            end else if (pend_v) begin
              state <= S_FLUSH;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= rtt_pkg::KIND_TIMEOUT;
            timer_id      <= pend_id;
            notify_dest   <= pend_dest;
            timeout_count <= pend_cnt;
            last          <= 1'b0;
            pend_v        <= 1'b0;
            div_start     <= best.periodic;
            cnt           <= 32'd1;
            state         <= best.periodic ? S_DIV : S_SAT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt   <= ((div_q[47:32] != 16'd0) || (div_q[31:0] == rtt_pkg::MASK32))
                     ? rtt_pkg::MASK32 : div_q[31:0] + 32'd1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 64'(div_b) * 64'(cnt);
          state <= S_SAT;
        end
        S_SAT: begin
          // commit the firing and start the next search, unless the result cap is reached
          bc.upd          <= 1'b1;
          bc.upd_slot     <= best.slot;
          bc.upd_kill     <= !best.periodic;
          bc.upd_deadline <= adv_dl;
          pend_v          <= 1'b1;
          pend_id         <= best.id;
          pend_dest       <= best.dest;
          pend_cnt        <= cnt;
          n               <= n + 1'b1;
          if (n == rtt_pkg::CNT_W'(rtt_pkg::MAX_RESULTS - 1)) begin
            state <= S_FLUSH;
          end else begin
            start <= 1'b1;
            state <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= rtt_pkg::KIND_TIMEOUT;
            timer_id      <= pend_id;
            notify_dest   <= pend_dest;
            timeout_count <= pend_cnt;
            last          <= 1'b1;
            pend_v        <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rtt_checker.sv =====
// Port-level checks on the repeating timer table, bound to its top level.
// Depends on rtt_pkg and repeating_timer_table_macros.svh.
`default_nettype none
`include "repeating_timer_table_macros.svh"
module rtt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  notify_dest,
  input wire logic [31:0] timeout_count,
  input wire logic        last
);
  logic info_res;
  logic timeout_res;
  logic info_zero;

  assign info_res    = out_valid && (kind != rtt_pkg::KIND_TIMEOUT);
  assign timeout_res = out_valid && (kind == rtt_pkg::KIND_TIMEOUT);
  assign info_zero   = (notify_dest == 8'd0) && (timeout_count == 32'd0);

  `RTT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `RTT_ASSERT_IMP(a_add_last, clk, rst, info_res, last)
  `RTT_ASSERT_IMP(a_cnt_nonzero, clk, rst, timeout_res, timeout_count != 32'd0)
  `RTT_ASSERT_IMP(a_add_fields, clk, rst, info_res, info_zero)
  `RTT_ASSERT_IMP(a_busy_mid_tick, clk, rst, out_valid && !last, !in_ready)
endmodule

bind repeating_timer_table rtt_checker u_rtt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .notify_dest   (notify_dest),
  .timeout_count (timeout_count),
  .last          (last)
);
`default_nettype wire

// ===== tb/sv/repeating_timer_table_tb.sv =====
// Self-checking testbench for the repeating timer table: directed and random requests.
// Depends on rtt_pkg and the repeating_timer_table RTL; predicts every result itself.
`default_nettype none
module repeating_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SLOTS     = 16;
  localparam int  TICK_CAP  = 16;
  localparam int  RAND_REQS = 366;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int  SETTLE    = 1200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [7:0]  dest;
    logic [31:0] cnt;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = rtt_pkg::CMD_CANCEL;
  logic [7:0]  dest_id = '0;
  logic [31:0] delay = '0;
  logic [15:0] cancel_id = '0;
  logic [47:0] now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] timer_id;
  logic [7:0]  notify_dest;
  logic [31:0] timeout_count;
  logic        last;

  repeating_timer_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .dest_id(dest_id), .delay(delay), .cancel_id(cancel_id),
    .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .timer_id(timer_id), .notify_dest(notify_dest),
    .timeout_count(timeout_count), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the timer table
  logic        tbl_used [SLOTS];
  logic [15:0] tbl_id   [SLOTS];
  logic [7:0]  tbl_dest [SLOTS];
  logic [47:0] tbl_due  [SLOTS];
  logic        tbl_per  [SLOTS];
  logic [31:0] tbl_ivl  [SLOTS];
  logic [15:0] id_ctr;

  timer_result_t pending_q[$];
  int  errors = 0;
  int  reqs_sent = 0;
  int  results_seen = 0;
  int  timeouts_seen = 0;
  int  fulls_seen = 0;
  longint cyc = 0;

  // sender burst state
  int  burst_left = 0;
  logic [47:0] clock_now = '0;

  function automatic logic [47:0] add_sat48(logic [47:0] base, logic [63:0] inc);
    if (inc > {16'd0, rtt_pkg::MASK48 - base}) return rtt_pkg::MASK48;
    return base + inc[47:0];
  endfunction

  function automatic void expect_result(logic [1:0] k, logic [15:0] id, logic [7:0] d,
                                        logic [31:0] c, logic l);
    timer_result_t r;
    r.kind = k; r.id = id; r.dest = d; r.cnt = c; r.last = l;
    pending_q = {pending_q, r};
  endfunction

  function automatic void predict_request(logic [1:0] c, logic [7:0] d, logic [31:0] dl,
                                          logic [15:0] cid, logic [47:0] now);
    int free_slot, best, n;
    logic fired [SLOTS];
    logic [63:0] iv, q, cnt;
    logic [31:0] ivl;
    free_slot = -1;
    n = 0;
    if (c == rtt_pkg::CMD_ADD_ONE || c == rtt_pkg::CMD_ADD_PER) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_used[i]) free_slot = i;
      if (free_slot < 0) begin
        expect_result(rtt_pkg::KIND_FULL, '0, '0, '0, 1'b1);
        return;
      end
      ivl = (c == rtt_pkg::CMD_ADD_PER && dl == 0) ? 32'd1 : dl;
      tbl_used[free_slot] = 1'b1;
      tbl_id[free_slot]   = id_ctr;
      tbl_dest[free_slot] = d;
      tbl_due[free_slot]  = add_sat48(now, {32'd0, ivl});
      tbl_per[free_slot]  = (c == rtt_pkg::CMD_ADD_PER);
      tbl_ivl[free_slot]  = ivl;
      expect_result(rtt_pkg::KIND_ADDED, id_ctr, '0, '0, 1'b1);
      id_ctr = id_ctr + 16'd1;
    end else if (c == rtt_pkg::CMD_CANCEL) begin
      for (int i = 0; i < SLOTS; i++) if (tbl_used[i] && tbl_id[i] == cid) tbl_used[i] = 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) fired[i] = 1'b0;
      while (n < TICK_CAP) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_used[i] || fired[i] || tbl_due[i] > now) continue;
          if (best < 0 || tbl_due[i] < tbl_due[best] ||
              (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
            best = i;
        end
        if (best < 0) break;
        fired[best] = 1'b1;
        if (tbl_per[best]) begin
          iv  = (tbl_ivl[best] == 0) ? 64'd1 : {32'd0, tbl_ivl[best]};
          q   = {16'd0, now - tbl_due[best]} / iv;
          cnt = (q >= {32'd0, rtt_pkg::MASK32}) ? {32'd0, rtt_pkg::MASK32} : q + 64'd1;
          tbl_due[best] = add_sat48(tbl_due[best], iv * cnt);
        end else begin
          cnt = 64'd1;
          tbl_used[best] = 1'b0;
        end
        expect_result(rtt_pkg::KIND_TIMEOUT, tbl_id[best], tbl_dest[best], cnt[31:0], 1'b0);
        n++;
      end
      if (n > 0) pending_q[$].last = 1'b1;
    end
  endfunction

  // Drive one request, hold it until taken; returns at a falling edge with valid still high.
  task automatic send_request(logic [1:0] c, logic [7:0] d, logic [31:0] dl,
                              logic [15:0] cid, logic [47:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid  <= 1'b1;
    cmd       <= c;
    dest_id   <= d;
    delay     <= dl;
    cancel_id <= cid;
    now_time  <= now;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_request(c, d, dl, cid, now);
    reqs_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until the table has answered everything outstanding.
  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic test_add_extremes();
    send_request(rtt_pkg::CMD_ADD_ONE, 8'h00, 32'd0, 16'd0, 48'd0);
    // deadline saturates
    send_request(rtt_pkg::CMD_ADD_ONE, 8'hFF, rtt_pkg::MASK32, 16'hFFFF, rtt_pkg::MASK48);
    send_request(rtt_pkg::CMD_ADD_PER, 8'h5A, 32'd0, 16'd0, 48'd5);  // interval forced to one
    send_request(rtt_pkg::CMD_TICK, 8'h00, 32'd0, 16'd0, 48'd10);
    // nothing left expired
    send_request(rtt_pkg::CMD_TICK, 8'hFF, rtt_pkg::MASK32, 16'hFFFF, 48'd10);
    send_request(rtt_pkg::CMD_CANCEL, 8'h00, 32'd0, 16'd1, 48'd0);
    send_request(rtt_pkg::CMD_CANCEL, 8'h00, 32'd0, 16'd2, 48'd0);
    send_request(rtt_pkg::CMD_CANCEL, 8'h00, 32'd0, 16'hFFFF, 48'd0);  // matches nothing
  endtask

  task automatic test_full_and_saturation();
    logic [15:0] first_id;
    first_id = id_ctr;
    for (int i = 0; i < SLOTS; i++)
      send_request(rtt_pkg::CMD_ADD_PER, 8'(i * 17), 32'd1, 16'd0, 48'd0);
    send_request(rtt_pkg::CMD_ADD_ONE, 8'h33, 32'd7, 16'd0, 48'd0);   // refused, table full
    send_request(rtt_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 48'd1000);    // sixteen results at once
    // period count saturates, then the timers are still expired and fire again
    send_request(rtt_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, rtt_pkg::MASK48);
    send_request(rtt_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, rtt_pkg::MASK48);
    for (int i = 0; i < SLOTS; i++)
      send_request(rtt_pkg::CMD_CANCEL, 8'd0, 32'd0, first_id + 16'(i), 48'd0);
  endtask

  task automatic test_random_traffic();
    int sel;
    logic [1:0]  c;
    logic [31:0] dl;
    logic [47:0] now;
    logic [15:0] cid;
    for (int i = 0; i < RAND_REQS; i++) begin
      if (i == RAND_REQS / 2) drain_results(0);
      clock_now = clock_now + 48'($urandom_range(0, 40));
      now = clock_now;
      if ($urandom_range(0, 19) == 0) now = {16'($urandom), $urandom};
      sel = $urandom_range(0, 99);
      c = (sel < 25) ? rtt_pkg::CMD_ADD_ONE : (sel < 45) ? rtt_pkg::CMD_ADD_PER :
          (sel < 65) ? rtt_pkg::CMD_CANCEL : rtt_pkg::CMD_TICK;
      dl = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 60));
      cid = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                       : id_ctr - 16'($urandom_range(1, 24));
      send_request(c, 8'($urandom), dl, cid, now);
    end
  endtask

  // receiver back-pressure: a per-phase pattern, sometimes always ready
  logic [15:0] stall_pat = 16'hFFFF;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0)
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
    out_ready <= stall_pat[cyc[3:0]];
  end

  always @(posedge clk) begin
    timer_result_t want;
    cyc <= cyc + 1;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (kind == rtt_pkg::KIND_TIMEOUT) timeouts_seen++;
      if (kind == rtt_pkg::KIND_FULL) fulls_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d timer_id=%0d", kind, timer_id);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind); errors++;
        end
        if (timer_id !== want.id) begin
          $error("timer_id: expected %0d, got %0d", want.id, timer_id); errors++;
        end
        if (notify_dest !== want.dest) begin
          $error("notify_dest: expected %0d, got %0d", want.dest, notify_dest); errors++;
        end
        if (timeout_count !== want.cnt) begin
          $error("timeout_count: expected %0d, got %0d", want.cnt, timeout_count); errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last); errors++;
        end
      end
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
    id_ctr = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_add_extremes();
    test_full_and_saturation();
    test_random_traffic();
    drain_results(SETTLE);
    $display("covered %0d requests: adds, full table, cancels, ticks with saturation",
             reqs_sent);
    $display("checked %0d results, %0d timeouts, %0d refusals",
             results_seen, timeouts_seen, fulls_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
